### hdl/sorted_table_linear_interpolator_macros.svh
// Assertion macros for the sorted table interpolator.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef SORTED_TABLE_LINEAR_INTERPOLATOR_MACROS_SVH
`define SORTED_TABLE_LINEAR_INTERPOLATOR_MACROS_SVH
`ifndef ASSERT_OFF
`define STLI_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define STLI_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define STLI_ASSERT(label, clk, rst, prop, msg)
`define STLI_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

### hdl/stli_pkg.sv
// Shared types and codes for the sorted table interpolator.
// No dependencies.
package stli_pkg;
  localparam int unsigned KEY_W = 16;
  localparam int unsigned VAL_W = 16;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0, CMD_QUERY = 2'd1, CMD_CLEAR = 2'd2, CMD_NONE = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_EXACT = 3'd0, ST_INTERP = 3'd1, ST_EXTRAP = 3'd2, ST_FEW = 3'd3, ST_SPAN = 3'd4
  } status_t;

  typedef struct packed {
    logic [1:0]        cmd;
    logic signed [15:0] angle;
    logic signed [15:0] coef;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] value;
    logic [2:0]         status;
  } out_item_t;

  // per-cell compare flags handed to the controller
  typedef struct packed {
    logic valid;   // entry in use
    logic eq;      // key == probe
    logic le;      // key <= probe
    logic lt;      // key < probe
  } cell_flags_t;
endpackage

### hdl/stli_if.sv
// Valid/ready channel interface carrying one payload.
// Depends on stli_pkg for payload types.
interface stli_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hdl/stli_cell.sv
// One table cell: holds a key/value pair, shifts from its left neighbor on insert.
// Depends on stli_pkg.
module stli_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       clear,
  input  logic                       shift_en,   // insert pass active
  input  logic signed [15:0]         ins_key,
  input  logic signed [15:0]         ins_val,
  input  logic                       left_valid,
  input  logic                       left_le,    // left neighbor key <= ins_key
  input  logic signed [15:0]         left_key,
  input  logic signed [15:0]         left_val,
  input  logic signed [15:0]         probe,
  output logic signed [15:0]         key,
  output logic signed [15:0]         val,
  output stli_pkg::cell_flags_t      flags
);
  import stli_pkg::*;
  logic valid;

  assign flags.valid = valid;
  assign flags.eq    = valid && (key == probe);
  assign flags.le    = valid && (key <= probe);
  assign flags.lt    = valid && (key < probe);

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      valid <= 1'b0;
    end else if (shift_en) begin
      // insert point is where this cell's key exceeds the new key (or is empty)
      if (!valid || !flags.le) begin
        if (left_valid && !left_le) begin
          key <= left_key;
          val <= left_val;
        end else begin
          key <= ins_key;
          val <= ins_val;
        end
        // an empty cell fills only when its left neighbor holds an entry
        if (left_valid) valid <= 1'b1;
      end
    end
  end
endmodule

### hdl/stli_divider.sv
// Serial restoring divider with round-half-away rounding of magnitudes.
// Depends on stli_pkg.
module stli_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [32:0] num,   // magnitude
  input  logic [16:0] den,   // magnitude, nonzero
  output logic        done,
  output logic [33:0] quo
);
  import stli_pkg::*;
  localparam int unsigned NW = 34;
  logic [NW-1:0] n2;
  logic [17:0]   d2;
  logic [18:0]   rem;
  logic [5:0]    cnt;
  logic          busy;
  logic [18:0]   trial;

  assign trial = {rem[17:0], n2[NW-1]} - {1'b0, d2};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        // (2n + d) / (2d)
        n2   <= {num, 1'b0} + {17'd0, den};
        d2   <= {den, 1'b0};
        rem  <= '0;
        cnt  <= 6'(NW);
        busy <= 1'b1;
      end else if (busy) begin
        if (!trial[18]) begin
          rem <= trial;
          quo <= {quo[NW-2:0], 1'b1};
        end else begin
          rem <= {rem[17:0], n2[NW-1]};
          quo <= {quo[NW-2:0], 1'b0};
        end
        n2  <= {n2[NW-2:0], 1'b0};
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

### hdl/sorted_table_linear_interpolator.sv
// Sorted table interpolator.
// Channels: in_ch carries {cmd, angle, coef}; out_ch carries {value, status}.
// A load inserts the pair: every cell compares its key with the
// new key and either keeps, shifts from its left neighbor, or takes the pair.
// Clear empties the table. Load and clear give no result, and the next
// transfer can follow in the very next cycle.
// A query does the cell row compare, bracket pick and differences in the
// pick step; then a 17x17 product feeds a serial divider that yields one
// quotient bit per cycle. Exact hits and error cases skip the product and
// the divider and go straight from the pick step to the output register.
// One item is worked on at a time; the result sits in an output register
// until taken, and a new input is accepted while it waits.
// Reset empties the table and drops any pending result.
// A stalled receiver holds the result; the next query is computed and then
// waits for the slot, holding off input meanwhile.
// Depends on stli_pkg, stli_if, stli_cell, stli_divider and the macro header.
`include "sorted_table_linear_interpolator_macros.svh"
module sorted_table_linear_interpolator #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input logic clk,
  input logic rst,
  stli_if.sink   in_ch,
  stli_if.source out_ch
);
  import stli_pkg::*;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  typedef enum logic [2:0] {S_IDLE, S_PICK, S_MUL, S_DIV, S_OUT} state_t;
  state_t state;

  logic signed [15:0] keys [TABLE_DEPTH];
  logic signed [15:0] vals [TABLE_DEPTH];
  cell_flags_t        flags [TABLE_DEPTH];
  logic [CW-1:0]      count;
  logic signed [15:0] probe;
  logic signed [15:0] qangle;
  logic               do_ins, do_clr, accept;
  logic               out_load;
  in_item_t           it;

  assign it     = in_ch.data;
  assign accept = in_ch.valid && in_ch.ready;
  assign do_ins = accept && (it.cmd == CMD_LOAD) && (count < CW'(TABLE_DEPTH));
  assign do_clr = accept && (it.cmd == CMD_CLEAR);
  assign in_ch.ready = (state == S_IDLE);
  assign out_load = (state == S_OUT) && (!out_ch.valid || out_ch.ready);

  always_comb begin
    probe = (state == S_IDLE) ? it.angle : qangle;
  end

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    logic signed [15:0] lk, lv;
    logic lvld, lle;
    if (g == 0) begin : g_first
      // cell 0 sees a filled left neighbor that sorts below every key
      assign lk = '0; assign lv = '0; assign lvld = 1'b1; assign lle = 1'b1;
    end else begin : g_rest
      assign lk = keys[g-1]; assign lv = vals[g-1];
      assign lvld = flags[g-1].valid; assign lle = flags[g-1].le;
    end
    stli_cell u_cell (
      .clk(clk), .rst(rst), .clear(do_clr), .shift_en(do_ins),
      .ins_key(it.angle), .ins_val(it.coef),
      .left_valid(lvld), .left_le(lle), .left_key(lk), .left_val(lv),
      .probe(probe), .key(keys[g]), .val(vals[g]), .flags(flags[g])
    );
  end

  // bracket / match search over the cell flags
  logic          hit, bra;
  logic [IW-1:0] hit_i, bra_i;
  always_comb begin
    hit = 1'b0; hit_i = '0; bra = 1'b0; bra_i = '0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (flags[i].eq) begin hit = 1'b1; hit_i = IW'(i); end
    end
    for (int i = 0; i + 1 < TABLE_DEPTH; i++) begin
      if (flags[i].lt && flags[i+1].valid && !flags[i+1].le) begin
        bra = 1'b1; bra_i = IW'(i);
      end
    end
  end

  logic signed [16:0] dx, dy, dc;
  logic signed [15:0] fa;
  logic signed [33:0] prod;
  logic               neg;
  logic               dstart, ddone;
  logic [33:0]        dq;
  logic signed [35:0] sum;
  out_item_t          res;

  // operands are 17-bit signed; the product needs 34 bits
  assign prod = 34'(dx) * 34'(dy);

  stli_divider u_div (
    .clk(clk), .rst(rst), .start(dstart),
    .num(prod[33] ? 33'(-prod) : prod[32:0]),
    .den(dc[16] ? 17'(-dc) : dc[16:0]),
    .done(ddone), .quo(dq)
  );
  assign dstart = (state == S_MUL);
  assign sum = 36'(fa) + (neg ? -$signed({2'b0, dq}) : $signed({2'b0, dq}));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      if (out_load) out_ch.valid <= 1'b1;
      else if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
      if (out_load) out_ch.data <= res;
      if (do_clr) count <= '0;
      if (do_ins) count <= count + CW'(1);
      case (state)
        S_IDLE: if (accept && it.cmd == CMD_QUERY) begin
          qangle <= it.angle;
          state  <= S_PICK;
        end
        S_PICK: begin
          if (hit) begin
            res <= '{value: vals[hit_i], status: ST_EXACT};
            state <= S_OUT;
          end else if (count < CW'(2)) begin
            res <= '{value: '0, status: ST_FEW};
            state <= S_OUT;
          end else if (bra) begin
            fa <= vals[bra_i];
            dx <= 17'(qangle) - 17'(keys[bra_i]);
            dy <= 17'(vals[bra_i+IW'(1)]) - 17'(vals[bra_i]);
            dc <= 17'(keys[bra_i+IW'(1)]) - 17'(keys[bra_i]);
            res.status <= ST_INTERP;
            state <= S_MUL;
          end else if (keys[0] == keys[1]) begin
            res <= '{value: '0, status: ST_SPAN};
            state <= S_OUT;
          end else begin
            fa <= vals[0];
            dx <= 17'(qangle) - 17'(keys[0]);
            dy <= 17'(vals[1]) - 17'(vals[0]);
            dc <= 17'(keys[1]) - 17'(keys[0]);
            res.status <= ST_EXTRAP;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          neg   <= (dx[16] ^ dy[16] ^ dc[16]) && (dx != 0) && (dy != 0);
          state <= S_DIV;
        end
        S_DIV: if (ddone) begin
          if (sum > 36'sd32767) res.value <= 16'sd32767;
          else if (sum < -36'sd32768) res.value <= -16'sd32768;
          else res.value <= sum[15:0];
          state <= S_OUT;
        end
        S_OUT: if (out_load) begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `STLI_ASSERT(a_cnt_max, clk, rst, count <= CW'(TABLE_DEPTH), "entry count overflow")
  `STLI_ASSERT(a_no_acc_busy, clk, rst, (state != S_IDLE) |-> !in_ch.ready, "accept while busy")
  `STLI_ASSERT(a_out_hold, clk, rst, (out_ch.valid && !out_ch.ready) |=> $stable(out_ch.data), "result changed under stall")
  `STLI_ASSERT(a_div_done, clk, rst, ddone |-> (state == S_DIV), "divider done outside divide")
endmodule
